// ----- hw/rtl/chsd_pkg.sv -----
// Shared types and constants of the canonical Huffman stream decoder.
`default_nettype none

package chsd_pkg;

    localparam int WINDOW_BITS_DEF = 32;
    localparam int SYMBOL_COUNT    = 256;
    localparam int BYTE_BITS       = 8;
    localparam int MAX_OCTETS      = 15;

    // Header and body phases of one encoded buffer.
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_LENGTH,
        PH_SECTIONS,
        PH_SECCOUNT,
        PH_SECSYMS,
        PH_SINGLE,
        PH_RAW,
        PH_DECODE
    } t_phase;

endpackage

`default_nettype wire

// ----- hw/rtl/chsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module chsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hw/rtl/canonical_huffman_stream_decoder.sv -----
// Top level of the canonical Huffman stream decoder.
//
// The block takes one byte of an encoded buffer per item and works on one item at a
// time. The section-count byte that opens a coded header clears the 256-entry
// code-length memory. The byte that closes the last section builds the canonical
// tables with one pass over the code-length memory for each code length up to
// min(section count, WINDOW_BITS). In the body each decoded symbol scans length
// entries in the table memory (up to the number of distinct lengths plus one), then
// reads the symbol memory and forms the result, so a byte that yields several symbols
// holds off the next item until all of them are handed over. Result items wait in one
// output register.
`default_nettype none

module canonical_huffman_stream_decoder
    import chsd_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_final_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_symbol,
    output logic [31:0]      o_repeat_count,
    output logic             o_stream_done,
    output logic             o_header_error,
    output logic             o_last_of_run
);

    localparam int W   = WINDOW_BITS;
    localparam int BW  = W + BYTE_BITS;
    localparam int CW  = $clog2(BW + 1);
    localparam int EW  = $clog2(W + 1);
    localparam int TAW = $clog2(W);
    localparam int SAW = $clog2(SYMBOL_COUNT);
    localparam int TW  = 2 * W + 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROC,
        S_CLR,
        S_BLD,
        S_BEND,
        S_DEC,
        S_LK_RD,
        S_LK_CMP,
        S_SYM_RD,
        S_SYM,
        S_FIN
    } t_state;

    function automatic logic [W-1:0] top_bits(input logic [W-1:0] win, input logic [7:0] len);
        logic [7:0] sh;
        sh = 8'(W) - len;
        return win >> sh;
    endfunction

    t_state          r_state;
    t_phase          r_phase;
    logic [3:0]      r_octets;
    logic [31:0]     r_rem;
    logic [7:0]      r_sec_total;
    logic [7:0]      r_sec_cur;
    logic [7:0]      r_sec_left;
    logic [EW-1:0]   r_entry_total;
    logic [BW-1:0]   r_buf;
    logic [CW-1:0]   r_cnt;
    logic [7:0]      r_b;
    logic            r_fin;
    logic [SAW:0]    r_j;
    logic [SAW-1:0]  r_pj;
    logic            r_pv;
    logic [7:0]      r_len;
    logic [7:0]      r_lmax;
    logic [W-1:0]    r_k;
    logic [SAW:0]    r_n;
    logic [EW-1:0]   r_m;
    logic            r_started;
    logic            r_err;
    logic [EW-1:0]   r_i;
    logic [W-1:0]    r_e_off;
    logic [7:0]      r_e_bits;
    logic            r_rep_mode;
    logic            r_o_valid;
    logic [7:0]      r_o_symbol;
    logic [31:0]     r_o_repeat;
    logic            r_o_done;
    logic            r_o_err;
    logic            r_o_last;

    // Memory ports.
    logic            len_we;
    logic [SAW-1:0]  len_waddr;
    logic [7:0]      len_wdata;
    logic [7:0]      len_rd;
    logic            sym_we;
    logic [7:0]      sym_rd;
    logic [SAW-1:0]  sym_idx;
    logic            tbl_we;
    logic [TW-1:0]   tbl_wdata;
    logic [TW-1:0]   tbl_rd;

    logic [W-1:0]    win;
    logic [W-1:0]    t_first;
    logic [W-1:0]    t_off;
    logic [7:0]      t_bits;
    logic [W-1:0]    top_t;
    logic [W-1:0]    top_e;
    logic            lk_pass;
    logic            bld_match;
    logic [CW-1:0]   dec_cnt;
    logic [BW-1:0]   dec_buf;
    logic [3:0]      oct_dec;
    logic            out_free;

    logic            e_go;
    logic [7:0]      e_sym;
    logic [31:0]     e_rep;
    logic            e_done;
    logic            e_err;
    logic            e_last;

    assign win      = r_buf[BW-1 -: W];
    assign t_first  = tbl_rd[TW-1 -: W];
    assign t_off    = tbl_rd[W+7:8];
    assign t_bits   = tbl_rd[7:0];
    assign top_t    = top_bits(win, t_bits);
    assign top_e    = top_bits(win, r_e_bits);
    assign lk_pass  = (r_i < r_entry_total) && (t_first <= top_t);
    assign sym_idx  = SAW'(top_e - r_e_off);
    assign out_free = !r_o_valid || !i_stall;
    assign oct_dec  = (r_octets != 4'd0) ? r_octets - 4'd1 : 4'd0;

    assign bld_match = r_pv && (len_rd == r_len);
    assign dec_buf   = r_buf << r_e_bits;
    assign dec_cnt   = (8'(r_cnt) > r_e_bits) ? r_cnt - CW'(r_e_bits) : '0;

    assign len_we    = (r_state == S_CLR) || (r_state == S_PROC && r_phase == PH_SECSYMS);
    assign len_waddr = (r_state == S_CLR) ? r_j[SAW-1:0] : r_b;
    assign len_wdata = (r_state == S_CLR) ? 8'd0 : r_sec_cur;

    assign sym_we    = (r_state == S_BLD) && bld_match;
    assign tbl_we    = (r_state == S_BLD) && bld_match && !r_started;
    assign tbl_wdata = {r_k, r_k - W'(r_n), r_len};

    chsd_ram #(.WIDTH(8), .DEPTH(SYMBOL_COUNT)) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (len_we),
        .i_wr_addr (len_waddr),
        .i_wr_data (len_wdata),
        .i_rd_addr (r_j[SAW-1:0]),
        .o_rd_data (len_rd)
    );

    chsd_ram #(.WIDTH(8), .DEPTH(SYMBOL_COUNT)) u_sym_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sym_we),
        .i_wr_addr (r_n[SAW-1:0]),
        .i_wr_data (r_pj),
        .i_rd_addr (sym_idx),
        .o_rd_data (sym_rd)
    );

    chsd_ram #(.WIDTH(TW), .DEPTH(W)) u_tbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (r_m[TAW-1:0]),
        .i_wr_data (tbl_wdata),
        .i_rd_addr (r_i[TAW-1:0]),
        .o_rd_data (tbl_rd)
    );

    // Result formation; every result knows at once whether another follows in this item.
    always_comb begin
        e_go   = 1'b0;
        e_sym  = r_b;
        e_rep  = 32'd1;
        e_done = 1'b0;
        e_err  = 1'b0;
        e_last = 1'b1;
        case (r_state)
            S_PROC: begin
                if (r_phase == PH_SINGLE && r_rem != 32'd0 && out_free) begin
                    e_go   = 1'b1;
                    e_rep  = r_rem;
                    e_done = 1'b1;
                end else if (r_phase == PH_RAW && r_rem != 32'd0 && out_free) begin
                    e_go   = 1'b1;
                    e_done = (r_rem == 32'd1);
                end
            end
            S_SYM: begin
                e_go  = out_free;
                e_sym = sym_rd;
                if (r_rep_mode) begin
                    e_rep  = r_rem;
                    e_done = 1'b1;
                end else begin
                    e_done = (r_rem == 32'd1);
                    e_last = !((r_rem != 32'd1) && ((dec_cnt >= CW'(W)) || r_fin));
                end
            end
            S_BEND: begin
                if ((r_err || r_m == '0) && out_free) begin
                    e_go  = 1'b1;
                    e_sym = 8'd0;
                    e_rep = 32'd0;
                    e_err = 1'b1;
                end
            end
            default: begin
                e_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_COUNT;
            r_octets      <= '0;
            r_rem         <= '0;
            r_sec_total   <= '0;
            r_sec_cur     <= '0;
            r_sec_left    <= '0;
            r_entry_total <= '0;
            r_buf         <= '0;
            r_cnt         <= '0;
            r_fin         <= 1'b0;
            r_j           <= '0;
            r_pv          <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (e_go) begin
                r_o_valid  <= 1'b1;
                r_o_symbol <= e_sym;
                r_o_repeat <= e_rep;
                r_o_done   <= e_done;
                r_o_err    <= e_err;
                r_o_last   <= e_last;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_b     <= i_data_byte;
                        r_fin   <= i_final_byte;
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    case (r_phase)
                        PH_COUNT: begin
                            r_rem   <= '0;
                            r_state <= S_FIN;
                            if (r_b == 8'd0) begin
                                r_phase <= PH_RAW;
                            end else begin
                                r_octets <= (r_b > 8'(MAX_OCTETS)) ? 4'(MAX_OCTETS) : r_b[3:0];
                                r_phase  <= PH_LENGTH;
                            end
                        end
                        PH_LENGTH: begin
                            r_rem    <= {r_rem[23:0], r_b};
                            r_octets <= oct_dec;
                            r_state  <= S_FIN;
                            if (oct_dec == 4'd0) begin
                                r_phase <= PH_SECTIONS;
                            end
                        end
                        PH_SECTIONS: begin
                            if (r_b == 8'd0) begin
                                r_phase <= PH_RAW;
                                r_state <= S_FIN;
                            end else if (r_b == 8'd1) begin
                                r_phase <= PH_SINGLE;
                                r_state <= S_FIN;
                            end else begin
                                r_sec_total   <= r_b;
                                r_sec_cur     <= 8'd1;
                                r_entry_total <= '0;
                                r_phase       <= PH_SECCOUNT;
                                r_j           <= '0;
                                r_state       <= S_CLR;
                            end
                        end
                        PH_SECCOUNT, PH_SECSYMS: begin
                            // A section ends on a zero count or on its last symbol.
                            if ((r_phase == PH_SECCOUNT && r_b == 8'd0) ||
                                (r_phase == PH_SECSYMS && r_sec_left == 8'd1)) begin
                                if (r_phase == PH_SECSYMS) begin
                                    r_sec_left <= 8'd0;
                                end
                                if (r_sec_cur >= r_sec_total) begin
                                    r_j       <= '0;
                                    r_pv      <= 1'b0;
                                    r_len     <= 8'd1;
                                    r_lmax    <= (r_sec_total > 8'(W)) ? 8'(W) : r_sec_total;
                                    r_k       <= '0;
                                    r_n       <= '0;
                                    r_m       <= '0;
                                    r_started <= 1'b0;
                                    r_err     <= 1'b0;
                                    r_state   <= S_BLD;
                                end else begin
                                    r_sec_cur <= r_sec_cur + 8'd1;
                                    r_phase   <= PH_SECCOUNT;
                                    r_state   <= S_FIN;
                                end
                            end else if (r_phase == PH_SECCOUNT) begin
                                r_sec_left <= r_b;
                                r_phase    <= PH_SECSYMS;
                                r_state    <= S_FIN;
                            end else begin
                                r_sec_left <= r_sec_left - 8'd1;
                                r_state    <= S_FIN;
                            end
                        end
                        PH_SINGLE: begin
                            if (r_rem != 32'd0 && !out_free) begin
                                r_state <= S_PROC;
                            end else begin
                                r_rem   <= '0;
                                r_phase <= PH_RAW;
                                r_state <= S_FIN;
                            end
                        end
                        PH_RAW: begin
                            if (r_rem != 32'd0 && !out_free) begin
                                r_state <= S_PROC;
                            end else begin
                                if (r_rem != 32'd0) begin
                                    r_rem <= r_rem - 32'd1;
                                end
                                r_state <= S_FIN;
                            end
                        end
                        PH_DECODE: begin
                            if (r_rem != 32'd0) begin
                                r_buf   <= r_buf | ({r_b, {W{1'b0}}} >> r_cnt);
                                r_cnt   <= r_cnt + CW'(BYTE_BITS);
                                r_state <= S_DEC;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_CLR: begin
                    r_j <= r_j + 1'b1;
                    if (r_j[SAW-1:0] == '1) begin
                        r_state <= S_FIN;
                    end
                end
                S_BLD: begin
                    // The length of a symbol is compared in the cycle after its read.
                    r_pj <= r_j[SAW-1:0];
                    r_pv <= !r_j[SAW];
                    if (!r_j[SAW]) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_pv) begin
                        if (len_rd > 8'(W)) begin
                            r_err <= 1'b1;
                        end
                        if (bld_match) begin
                            r_started <= 1'b1;
                            r_k       <= r_k + 1'b1;
                            r_n       <= r_n + 1'b1;
                        end
                    end else if (r_j[SAW]) begin
                        r_k <= r_k << 1;
                        if (r_started) begin
                            r_m <= r_m + 1'b1;
                        end
                        if (r_len >= r_lmax) begin
                            r_state <= S_BEND;
                        end else begin
                            r_len     <= r_len + 8'd1;
                            r_j       <= '0;
                            r_started <= 1'b0;
                        end
                    end
                end
                S_BEND: begin
                    if (r_err || r_m == '0) begin
                        if (out_free) begin
                            r_rem   <= '0;
                            r_phase <= PH_RAW;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_entry_total <= r_m;
                        r_phase       <= PH_DECODE;
                        r_buf         <= '0;
                        r_cnt         <= '0;
                        r_state       <= r_fin ? S_DEC : S_FIN;
                    end
                end
                S_DEC: begin
                    r_i <= '0;
                    if (r_rem != 32'd0 && (r_cnt >= CW'(W) || (r_fin && r_cnt != '0))) begin
                        r_rep_mode <= 1'b0;
                        r_state    <= S_LK_RD;
                    end else if (r_rem != 32'd0 && r_fin) begin
                        // No real bits remain: the same symbol stands for the rest.
                        r_rep_mode <= 1'b1;
                        r_state    <= S_LK_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_LK_RD: begin
                    r_state <= S_LK_CMP;
                end
                S_LK_CMP: begin
                    if (lk_pass || r_i == '0) begin
                        r_e_off  <= t_off;
                        r_e_bits <= t_bits;
                    end
                    if (lk_pass) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LK_RD;
                    end else begin
                        r_state <= S_SYM_RD;
                    end
                end
                S_SYM_RD: begin
                    r_state <= S_SYM;
                end
                S_SYM: begin
                    if (out_free) begin
                        if (r_rep_mode) begin
                            r_rem   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_rem   <= r_rem - 32'd1;
                            r_buf   <= dec_buf;
                            r_cnt   <= dec_cnt;
                            r_state <= S_DEC;
                        end
                    end
                end
                S_FIN: begin
                    if (r_fin) begin
                        r_phase     <= PH_COUNT;
                        r_octets    <= '0;
                        r_rem       <= '0;
                        r_sec_total <= '0;
                        r_sec_cur   <= '0;
                        r_sec_left  <= '0;
                        r_buf       <= '0;
                        r_cnt       <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_symbol       = r_o_symbol;
    assign o_repeat_count = r_o_repeat;
    assign o_stream_done  = r_o_done;
    assign o_header_error = r_o_err;
    assign o_last_of_run  = r_o_last;

endmodule

`default_nettype wire

// ----- hw/rtl/chsd_checker.sv -----
// Port-level checks of the canonical Huffman stream decoder and their binding.
`default_nettype none

module chsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_data_byte,
    input wire logic        i_final_byte,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_symbol,
    input wire logic [31:0] o_repeat_count,
    input wire logic        o_stream_done,
    input wire logic        o_header_error,
    input wire logic        o_last_of_run
);

    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_repeat_count)
            && $stable(o_last_of_run))
        else $error("stalled result changed");

    // A header error is reported alone, with empty payload.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_header_error |-> o_symbol == 8'd0 && o_repeat_count == 32'd0
            && !o_stream_done && o_last_of_run)
        else $error("malformed header error result");

    // The result that completes the stream closes the item's results.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_done |-> o_last_of_run)
        else $error("stream done before last result of item");

    // Apart from header errors, only a completing result carries a repeat count other than one.
    a_rep_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_header_error && !o_stream_done |-> o_repeat_count == 32'd1)
        else $error("unexpected repeat count");

endmodule

bind canonical_huffman_stream_decoder chsd_checker u_chsd_checker (.*);

`default_nettype wire
